// ===== design/spc_pkg.sv =====
package spc_pkg;

  localparam int REQ_W   = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int STAT_W  = 2;
  localparam int CORR_W  = 16;
  localparam int NOUT_W  = 9;
  localparam int LOHI_W  = 15;
  localparam int ODD_W   = 16;
  localparam int OSQ_W   = 32;

  localparam logic [REQ_W-1:0] REQ_LOAD_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED      = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Q1.14 full scale
  localparam logic [LOHI_W-1:0] CORR_ONE = 15'd16384;

  typedef enum logic [3:0] {
    OP_N_SXY  = 4'd0,
    OP_SX_SY  = 4'd1,
    OP_N_SXX  = 4'd2,
    OP_SX_SX  = 4'd3,
    OP_N_SYY  = 4'd4,
    OP_SY_SY  = 4'd5,
    OP_DXDY   = 4'd6,
    OP_RHS    = 4'd7,
    OP_ODD    = 4'd8,
    OP_LHS    = 4'd9
  } mul_op_t;

  typedef struct packed {
    logic    idle;
    logic    walk_acc;
    logic    walk_cmp;
    logic    mul_start;
    mul_op_t mul_op;
    logic    res_push;
  } cmd_t;

  typedef struct packed {
    logic walk_more;
    logic mul_done;
    logic srch_more;
    logic zero_den;
  } sts_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [CORR_W-1:0] correlation;
    logic [NOUT_W-1:0]        common_count;
  } res_t;

endpackage

// ===== design/spc_if.sv =====
interface spc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        entry_key;
  logic signed [15:0] entry_value;

  modport source (output valid, output req_type, output entry_key, output entry_value,
                  input ready);
  modport sink (input valid, input req_type, input entry_key, input entry_value,
                output ready);
endinterface

interface spc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] correlation;
  logic [8:0]         common_count;

  modport source (output valid, output status, output correlation, output common_count,
                  input ready);
  modport sink (input valid, input status, input correlation, input common_count,
                output ready);
endinterface

// ===== design/spc_mul.sv =====
module spc_mul #(
  parameter int MW = 132,
  parameter int NW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] a_in,
  input  logic [MW-1:0] b_in,
  input  logic [NW-1:0] cnt_in,
  output logic          done,
  output logic [MW-1:0] prod
);

  logic [MW-1:0] acc_r, a_r, b_r;
  logic [NW-1:0] left_r;
  logic          busy_r, done_r;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        left_r <= cnt_in;
        acc_r  <= '0;
        a_r    <= a_in;
        b_r    <= b_in;
      end else if (busy_r) begin
        acc_r  <= acc_r + (b_r[0] ? a_r : '0);
        a_r    <= a_r << 1;
        b_r    <= b_r >> 1;
        left_r <= left_r - NW'(1);
        if (left_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("multiplier restarted while busy");

endmodule

// ===== design/spc_outq.sv =====
module spc_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spc_pkg::res_t push_data,
  input  logic          pop,
  output logic          q_valid,
  output spc_pkg::res_t q_data,
  output logic          room
);
  import spc_pkg::*;

  res_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = slot_r[rp_r];
  assign room    = (cnt_r != 2'd2);
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> room)
    else $error("result pushed into full queue");

endmodule

// ===== design/spc_dp.sv =====
module spc_dp #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  logic [1:0]         req_type,
  input  logic [31:0]        entry_key,
  input  logic signed [15:0] entry_value,
  input  spc_pkg::cmd_t      cmd,
  output spc_pkg::sts_t      sts,
  output logic               push,
  output spc_pkg::res_t      push_res
);
  import spc_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = CW + 16;
  localparam int QW = CW + 32;
  localparam int DW = 2 * CW + 33;
  localparam int MW = 2 * DW + 30;
  localparam int NW = $clog2(DW + 16);
  localparam int EW = KEY_W + VAL_W;

  logic [EW-1:0] mem1 [MAX_ENTRIES];
  logic [EW-1:0] mem2 [MAX_ENTRIES];
  logic [EW-1:0] rd1_r, rd2_r;
  logic [CW-1:0] cnt1_r, cnt2_r, i_r, j_r, n_r;
  logic [KEY_W-1:0] last1_r, last2_r;
  logic pend_r;
  logic signed [VAL_W-1:0] xv_r, yv_r;
  logic signed [31:0] xx_r, yy_r, xy_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic signed [QW-1:0] sxx_r, syy_r, sxy_r;
  logic signed [DW-1:0] t_r, num_r, dx_r, dy_r;
  logic [MW-1:0] p_r, rhs_r;
  logic [OSQ_W-1:0] oddsq_r;
  logic [LOHI_W-1:0] lo_r, hi_r;

  // load checks
  logic is_l1, is_l2, is_cmp, full1, full2, ord1, ord2, wr1, wr2;
  logic [STAT_W-1:0] ld_stat;

  assign is_l1  = in_acc && (req_type == REQ_LOAD_FIRST);
  assign is_l2  = in_acc && (req_type == REQ_LOAD_SECOND);
  assign is_cmp = in_acc && (req_type == REQ_COMPUTE);
  assign full1  = (cnt1_r == CW'(MAX_ENTRIES));
  assign full2  = (cnt2_r == CW'(MAX_ENTRIES));
  assign ord1   = (cnt1_r != '0) && (entry_key <= last1_r);
  assign ord2   = (cnt2_r != '0) && (entry_key <= last2_r);
  assign wr1    = is_l1 && !full1 && !ord1;
  assign wr2    = is_l2 && !full2 && !ord2;

  always_comb begin
    ld_stat = STAT_OK;
    case (req_type)
      REQ_LOAD_FIRST:  ld_stat = full1 ? STAT_FULL : (ord1 ? STAT_ORDER : STAT_OK);
      REQ_LOAD_SECOND: ld_stat = full2 ? STAT_FULL : (ord2 ? STAT_ORDER : STAT_OK);
      default:         ld_stat = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr1) mem1[cnt1_r[AW-1:0]] <= {entry_key, entry_value};
    if (wr2) mem2[cnt2_r[AW-1:0]] <= {entry_key, entry_value};
    rd1_r <= mem1[i_r[AW-1:0]];
    rd2_r <= mem2[j_r[AW-1:0]];
  end

  // merge walk
  logic [KEY_W-1:0] k1, k2;
  logic signed [VAL_W-1:0] x, y;
  assign k1 = rd1_r[EW-1:VAL_W];
  assign k2 = rd2_r[EW-1:VAL_W];
  assign x  = rd1_r[VAL_W-1:0];
  assign y  = rd2_r[VAL_W-1:0];

  // search midpoint
  logic [LOHI_W:0]   m_sum;
  logic [LOHI_W-1:0] m;
  logic [ODD_W-1:0]  odd;
  logic [DW-1:0]     mag;
  logic              neg;

  assign m_sum = {1'b0, lo_r} + {1'b0, hi_r} + (LOHI_W+1)'(1);
  assign m     = m_sum[LOHI_W:1];
  assign odd   = {m, 1'b0} - ODD_W'(1);
  assign neg   = num_r[DW-1];
  assign mag   = neg ? DW'(-num_r) : DW'(num_r);

  // multiplier operands
  logic [MW-1:0] op_a, op_b, prod;
  logic [NW-1:0] op_n;
  logic          mul_done;
  logic signed [DW-1:0] prod_lo;

  assign prod_lo = prod[DW-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_n = NW'(DW);
    case (cmd.mul_op)
      OP_N_SXY: begin op_a = MW'(n_r); op_b = MW'(sxy_r); end
      OP_SX_SY: begin op_a = MW'(sx_r); op_b = MW'(sy_r); end
      OP_N_SXX: begin op_a = MW'(n_r); op_b = MW'(sxx_r); end
      OP_SX_SX: begin op_a = MW'(sx_r); op_b = MW'(sx_r); end
      OP_N_SYY: begin op_a = MW'(n_r); op_b = MW'(syy_r); end
      OP_SY_SY: begin op_a = MW'(sy_r); op_b = MW'(sy_r); end
      OP_DXDY:  begin op_a = MW'(dx_r); op_b = MW'(dy_r); end
      OP_RHS: begin
        op_a = MW'({mag, 15'd0});
        op_b = MW'({mag, 15'd0});
        op_n = NW'(DW + 15);
      end
      OP_ODD: begin op_a = MW'(odd); op_b = MW'(odd); op_n = NW'(ODD_W); end
      OP_LHS: begin op_a = p_r; op_b = MW'(oddsq_r); op_n = NW'(30); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  spc_mul #(.MW(MW), .NW(NW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .a_in   (op_a),
    .b_in   (op_b),
    .cnt_in (op_n),
    .done   (mul_done),
    .prod   (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r <= '0;
      cnt2_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (wr1) begin
        cnt1_r  <= cnt1_r + CW'(1);
        last1_r <= entry_key;
      end
      if (wr2) begin
        cnt2_r  <= cnt2_r + CW'(1);
        last2_r <= entry_key;
      end
      if (is_cmp) begin
        i_r    <= '0;
        j_r    <= '0;
        n_r    <= '0;
        sx_r   <= '0;
        sy_r   <= '0;
        sxx_r  <= '0;
        syy_r  <= '0;
        sxy_r  <= '0;
        pend_r <= 1'b0;
        lo_r   <= '0;
        hi_r   <= CORR_ONE;
      end
      if (cmd.walk_cmp) begin
        if (k1 < k2) begin
          pend_r <= 1'b0;
          i_r    <= i_r + CW'(1);
        end else if (k1 > k2) begin
          pend_r <= 1'b0;
          j_r    <= j_r + CW'(1);
        end else begin
          pend_r <= 1'b1;
          xv_r   <= x;
          yv_r   <= y;
          xx_r   <= x * x;
          yy_r   <= y * y;
          xy_r   <= x * y;
          i_r    <= i_r + CW'(1);
          j_r    <= j_r + CW'(1);
        end
      end
      if (cmd.walk_acc && pend_r) begin
        pend_r <= 1'b0;
        n_r    <= n_r + CW'(1);
        sx_r   <= sx_r + SW'(xv_r);
        sy_r   <= sy_r + SW'(yv_r);
        sxx_r  <= sxx_r + QW'(xx_r);
        syy_r  <= syy_r + QW'(yy_r);
        sxy_r  <= sxy_r + QW'(xy_r);
      end
      if (mul_done) begin
        case (cmd.mul_op)
          OP_N_SXY, OP_N_SXX, OP_N_SYY: t_r <= prod_lo;
          OP_SX_SY: num_r   <= t_r - prod_lo;
          OP_SX_SX: dx_r    <= t_r - prod_lo;
          OP_SY_SY: dy_r    <= t_r - prod_lo;
          OP_DXDY:  p_r     <= prod;
          OP_RHS:   rhs_r   <= prod;
          OP_ODD:   oddsq_r <= prod[OSQ_W-1:0];
          OP_LHS: begin
            if (prod <= rhs_r) lo_r <= m;
            else hi_r <= m - LOHI_W'(1);
          end
          default: t_r <= t_r;
        endcase
      end
      if (cmd.res_push) begin
        cnt1_r <= '0;
        cnt2_r <= '0;
      end
    end
  end

  // result assembly
  logic [CW+NOUT_W-1:0]     n_wide;
  logic signed [CORR_W-1:0] corr;
  logic                     zero_den;

  assign n_wide   = (CW+NOUT_W)'(n_r);
  assign zero_den = (dx_r == '0) || (dy_r == '0);
  assign corr     = zero_den ? '0 : (neg ? -CORR_W'(lo_r) : CORR_W'(lo_r));

  always_comb begin
    push_res = '0;
    if (cmd.res_push) begin
      push_res.status       = STAT_OK;
      push_res.correlation  = corr;
      push_res.common_count = n_wide[NOUT_W-1:0];
    end else begin
      push_res.status = ld_stat;
    end
  end

  assign push = (in_acc && (req_type != REQ_COMPUTE)) || cmd.res_push;

  assign sts.walk_more = (i_r < cnt1_r) && (j_r < cnt2_r);
  assign sts.mul_done  = mul_done;
  assign sts.srch_more = (lo_r < hi_r);
  assign sts.zero_den  = zero_den;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt1_r <= CW'(MAX_ENTRIES)) && (cnt2_r <= CW'(MAX_ENTRIES)))
    else $error("store count beyond capacity");

endmodule

// ===== design/spc_ctrl.sv =====
module spc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  logic          in_compute,
  input  spc_pkg::sts_t sts,
  output spc_pkg::cmd_t cmd
);
  import spc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WCHK   = 8'b0000_0010,
    S_WCMP   = 8'b0000_0100,
    S_MSTART = 8'b0000_1000,
    S_MWAIT  = 8'b0001_0000,
    S_ZCHK   = 8'b0010_0000,
    S_SCHK   = 8'b0100_0000,
    S_PUSH   = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  mul_op_t op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.mul_op = op_r;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_acc && in_compute) state_nxt = S_WCHK;
      end
      S_WCHK: begin
        cmd.walk_acc = 1'b1;
        if (sts.walk_more) begin
          state_nxt = S_WCMP;
        end else begin
          op_nxt    = OP_N_SXY;
          state_nxt = S_MSTART;
        end
      end
      S_WCMP: begin
        cmd.walk_cmp = 1'b1;
        state_nxt    = S_WCHK;
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          state_nxt = S_MSTART;
          case (op_r)
            OP_N_SXY: op_nxt = OP_SX_SY;
            OP_SX_SY: op_nxt = OP_N_SXX;
            OP_N_SXX: op_nxt = OP_SX_SX;
            OP_SX_SX: op_nxt = OP_N_SYY;
            OP_N_SYY: op_nxt = OP_SY_SY;
            OP_SY_SY: state_nxt = S_ZCHK;
            OP_DXDY:  op_nxt = OP_RHS;
            OP_RHS:   state_nxt = S_SCHK;
            OP_ODD:   op_nxt = OP_LHS;
            OP_LHS:   state_nxt = S_SCHK;
            default:  state_nxt = S_PUSH;
          endcase
        end
      end
      S_ZCHK: begin
        if (sts.zero_den) begin
          state_nxt = S_PUSH;
        end else begin
          op_nxt    = OP_DXDY;
          state_nxt = S_MSTART;
        end
      end
      S_SCHK: begin
        if (sts.srch_more) begin
          op_nxt    = OP_ODD;
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.res_push = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_N_SXY;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== design/sparse_pearson_correlation_top.sv =====
// Sparse Pearson correlation of two key/value vectors.
//
// in_if carries one request per beat: load an entry into the first or second
// vector (keys strictly ascending per vector), or compute. out_if returns one
// beat per request: load status, or for compute the coefficient in Q1.14 and
// the number of shared keys. Compute empties both vectors.
//
// A load (or unused request code) has its answer registered in the output queue.
// A compute walks both vectors in merge steps of a compare state and a check
// state (at most first_count + second_count steps), then runs a shift-add
// multiplier one bit per cycle: six products, then, unless a denominator term is
// zero, dx*dy and the right-hand side and a search of at most 15 steps of two
// products each; operand width DW = 2*clog2(N+1)+33. The serial multiplier sets
// the compute time; no new request is taken meanwhile.
//
// Results sit in a two-beat output queue, so loads keep flowing while the
// receiver stalls until the queue fills; then in_if.ready drops and holds.
// Reset (rst_n low, synchronous) empties both vectors and the queue; stored
// entries themselves are not cleared, no clearing pass is needed.
module sparse_pearson_correlation_top #(
  parameter int MAX_ENTRIES = 256
) (
  input logic      clk,
  input logic      rst_n,
  spc_in_if.sink   in_if,
  spc_out_if.source out_if
);
  import spc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t push_res, q_data;
  logic in_acc, push, room, q_valid;

  // take a beat only when idle and the queue can hold its answer
  assign in_if.ready = cmd.idle && room;
  assign in_acc      = in_if.valid && in_if.ready;

  spc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_compute (in_if.req_type == REQ_COMPUTE),
    .sts        (sts),
    .cmd        (cmd)
  );

  spc_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .req_type    (in_if.req_type),
    .entry_key   (in_if.entry_key),
    .entry_value (in_if.entry_value),
    .cmd         (cmd),
    .sts         (sts),
    .push        (push),
    .push_res    (push_res)
  );

  spc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .pop       (out_if.ready),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .room      (room)
  );

  // drive the result channel straight from the queue head
  assign out_if.valid        = q_valid;
  assign out_if.status       = q_data.status;
  assign out_if.correlation  = q_data.correlation;
  assign out_if.common_count = q_data.common_count;

  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_if.req_type == REQ_COMPUTE)) |=> !in_if.ready)
    else $error("request taken while compute runs");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_push |=> cmd.idle)
    else $error("controller not idle after compute result");

endmodule
